// ===== sv/jsu_pkg.sv =====
// Shared types and constants for the JSON string unescaper.
package jsu_pkg;

  // Result status codes carried with every output word.
  typedef enum logic [1:0] {
    ST_BYTE   = 2'd0,
    ST_CLOSED = 2'd1,
    ST_ERROR  = 2'd2
  } status_e;

  // Character codes that steer the decoder.
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChSlash     = 8'h2f;
  localparam logic [7:0] ChLowerB    = 8'h62;
  localparam logic [7:0] ChLowerF    = 8'h66;
  localparam logic [7:0] ChLowerN    = 8'h6e;
  localparam logic [7:0] ChLowerR    = 8'h72;
  localparam logic [7:0] ChLowerT    = 8'h74;
  localparam logic [7:0] ChLowerU    = 8'h75;

  // Control bytes produced by the short escapes.
  localparam logic [7:0] CtlBackspace = 8'h08;
  localparam logic [7:0] CtlFormFeed  = 8'h0c;
  localparam logic [7:0] CtlNewLine   = 8'h0a;
  localparam logic [7:0] CtlReturn    = 8'h0d;
  localparam logic [7:0] CtlTab       = 8'h09;

  // UTF-8 encoding limits and lead bytes.
  localparam logic [15:0] Utf8Max1 = 16'h0080;
  localparam logic [15:0] Utf8Max2 = 16'h0800;
  localparam logic [7:0]  Lead2    = 8'hc0;
  localparam logic [7:0]  Lead3    = 8'he0;
  localparam logic [7:0]  ContByte = 8'h80;
  localparam logic [7:0]  ContMask = 8'h3f;

  // Most result words one input word can cause.
  localparam int unsigned MaxResults = 3;

  // One result word.
  typedef struct packed {
    logic [7:0] data;
    status_e    status;
  } result_t;

  // All result words caused by one input word, with their count.
  typedef struct packed {
    result_t [MaxResults-1:0] res;
    logic [1:0]               count;
  } bundle_t;

endpackage

// ===== sv/jsu_in_if.sv =====
// Input channel: one raw byte or end-of-stream mark per word.
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] in_byte;

  modport source (output valid, output kind, output in_byte, input ready);
  modport sink (input valid, input kind, input in_byte, output ready);
endinterface

// ===== sv/jsu_out_if.sv =====
// Output channel: one decoded byte or status word per word.
interface jsu_out_if;
  logic              valid;
  logic              ready;
  logic [7:0]        out_byte;
  jsu_pkg::status_e  status;
  logic              last;

  modport source (output valid, output out_byte, output status, output last, input ready);
  modport sink (input valid, input out_byte, input status, input last, output ready);
endinterface

// ===== sv/json_string_unescaper_unit.sv =====
// Top level of the JSON string unescaper: input register, decoder and result register.
//
// The unit decodes quoted JSON strings from a byte stream: it takes one input word per clock
// while the result register has room, and returns one word per decoded byte, a closed word
// at the closing quote, or an error word. An input word is registered, decoded
// combinationally, and its result words (none, one, or up to three for a \u escape that
// needs three UTF-8 bytes) sit in a result register that hands out one word per cycle
// while the output is ready. Plain text streams through the input register and then the
// result register; a word with results waits until the register has sent out all earlier ones.
// Words that yield nothing (opening quote, backslash, \u, first three hex digits) skip the output.
module json_string_unescaper_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  jsu_in_if.sink    in_i,
  jsu_out_if.source out_o
);

  logic             in_vld_q;
  logic             kind_q;
  logic [7:0]       byte_q;
  jsu_pkg::bundle_t bundle;
  logic             buf_free;
  logic             consume;
  logic             load;

  // The registered word moves on when its results fit in the result register.
  assign consume  = in_vld_q && ((bundle.count == 2'd0) || buf_free);
  assign load     = consume && (bundle.count != 2'd0);
  assign in_i.ready = !in_vld_q || consume;

  // Input payload register.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      kind_q <= in_i.kind;
      byte_q <= in_i.in_byte;
    end
  end

  // Input occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  jsu_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .consume_i (consume),
    .kind_i    (kind_q),
    .in_byte_i (byte_q),
    .bundle_o  (bundle)
  );

  jsu_out_buf u_out_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (load),
    .bundle_i (bundle),
    .free_o   (buf_free),
    .out_o    (out_o)
  );

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !consume) |=> (in_vld_q && $stable(byte_q) && $stable(kind_q)))
    else $error("registered input word lost before it was decoded");

endmodule

// ===== sv/jsu_decode.sv =====
// Decoder state and combinational decode of one input word into its result words.
module jsu_decode (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             consume_i,
  input  logic             kind_i,
  input  logic [7:0]       in_byte_i,
  output jsu_pkg::bundle_t bundle_o
);

  typedef enum logic [1:0] {
    MODE_WAIT = 2'd0,
    MODE_TEXT = 2'd1,
    MODE_ESC  = 2'd2,
    MODE_HEX  = 2'd3
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [1:0]  hex_count_q, hex_count_d;
  logic [15:0] code_point_q, code_point_d;
  logic        bad_hex_q, bad_hex_d;

  logic [3:0]  hex_val;
  logic        hex_ok;
  logic [15:0] cp_next;

  // Hex digit value; a non-hex character counts as zero and is flagged.
  always_comb begin
    hex_ok  = 1'b0;
    hex_val = 4'd0;
    if (in_byte_i inside {[8'h30:8'h39]}) begin
      hex_ok  = 1'b1;
      hex_val = in_byte_i[3:0];
    end else if (in_byte_i inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      hex_ok  = 1'b1;
      hex_val = 4'({1'b0, in_byte_i[2:0]} + 4'd9);
    end
  end

  assign cp_next = {code_point_q[11:0], hex_val};

  // Next state and result words.
  always_comb begin
    mode_d       = mode_q;
    hex_count_d  = hex_count_q;
    code_point_d = code_point_q;
    bad_hex_d    = bad_hex_q;
    bundle_o     = '0;

    if (kind_i) begin
      bundle_o.res[0].status = jsu_pkg::ST_ERROR;
      bundle_o.count         = 2'd1;
      mode_d                 = MODE_WAIT;
    end else begin
      case (mode_q)
        MODE_WAIT: begin
          if (in_byte_i == jsu_pkg::ChQuote) begin
            mode_d = MODE_TEXT;
          end else begin
            bundle_o.res[0].status = jsu_pkg::ST_ERROR;
            bundle_o.count         = 2'd1;
          end
        end
        MODE_TEXT: begin
          if (in_byte_i == jsu_pkg::ChQuote) begin
            bundle_o.res[0].status = jsu_pkg::ST_CLOSED;
            bundle_o.count         = 2'd1;
            mode_d                 = MODE_WAIT;
          end else if (in_byte_i == jsu_pkg::ChBackslash) begin
            mode_d = MODE_ESC;
          end else begin
            bundle_o.res[0].data   = in_byte_i;
            bundle_o.res[0].status = jsu_pkg::ST_BYTE;
            bundle_o.count         = 2'd1;
          end
        end
        MODE_ESC: begin
          mode_d                 = MODE_TEXT;
          bundle_o.res[0].status = jsu_pkg::ST_BYTE;
          bundle_o.count         = 2'd1;
          case (in_byte_i)
            jsu_pkg::ChLowerB: bundle_o.res[0].data = jsu_pkg::CtlBackspace;
            jsu_pkg::ChLowerF: bundle_o.res[0].data = jsu_pkg::CtlFormFeed;
            jsu_pkg::ChLowerN: bundle_o.res[0].data = jsu_pkg::CtlNewLine;
            jsu_pkg::ChLowerR: bundle_o.res[0].data = jsu_pkg::CtlReturn;
            jsu_pkg::ChLowerT: bundle_o.res[0].data = jsu_pkg::CtlTab;
            jsu_pkg::ChQuote, jsu_pkg::ChSlash, jsu_pkg::ChBackslash:
              bundle_o.res[0].data = in_byte_i;
            jsu_pkg::ChLowerU: begin
              bundle_o.count = 2'd0;
              mode_d         = MODE_HEX;
              hex_count_d    = 2'd0;
              code_point_d   = '0;
              bad_hex_d      = 1'b0;
            end
            default: begin
              bundle_o.res[0].status = jsu_pkg::ST_ERROR;
              mode_d                 = MODE_WAIT;
            end
          endcase
        end
        default: begin
          // Gathering the four hex digits of a \u escape.
          code_point_d = cp_next;
          if (!hex_ok) begin
            bad_hex_d = 1'b1;
          end
          if (hex_count_q != 2'd3) begin
            hex_count_d = 2'(hex_count_q + 2'd1);
          end else begin
            hex_count_d = 2'd0;
            mode_d      = MODE_TEXT;
            bad_hex_d   = 1'b0;
            if (bad_hex_q || !hex_ok) begin
              bundle_o.res[0].status = jsu_pkg::ST_ERROR;
              bundle_o.count         = 2'd1;
              mode_d                 = MODE_WAIT;
            end else if (cp_next < jsu_pkg::Utf8Max1) begin
              bundle_o.res[0].data = cp_next[7:0];
              bundle_o.count       = 2'd1;
            end else if (cp_next < jsu_pkg::Utf8Max2) begin
              bundle_o.res[0].data = jsu_pkg::Lead2 | {3'b000, cp_next[10:6]};
              bundle_o.res[1].data = jsu_pkg::ContByte | (cp_next[7:0] & jsu_pkg::ContMask);
              bundle_o.count       = 2'd2;
            end else begin
              bundle_o.res[0].data = jsu_pkg::Lead3 | {4'b0000, cp_next[15:12]};
              bundle_o.res[1].data = jsu_pkg::ContByte | {2'b00, cp_next[11:6]};
              bundle_o.res[2].data = jsu_pkg::ContByte | (cp_next[7:0] & jsu_pkg::ContMask);
              bundle_o.count       = 2'd3;
            end
          end
        end
      endcase
    end
  end

  // Decoder state advances once per consumed input word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_WAIT;
      hex_count_q  <= 2'd0;
      code_point_q <= '0;
      bad_hex_q    <= 1'b0;
    end else if (consume_i) begin
      mode_q       <= mode_d;
      hex_count_q  <= hex_count_d;
      code_point_q <= code_point_d;
      bad_hex_q    <= bad_hex_d;
    end
  end

  // A \u escape always starts gathering from a clean digit count.
  a_hex_start_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume_i && !kind_i && (mode_q == MODE_ESC) && (in_byte_i == jsu_pkg::ChLowerU))
    |=> ((mode_q == MODE_HEX) && (hex_count_q == 2'd0) && !bad_hex_q))
    else $error("unicode escape did not start from a clean digit count");

endmodule

// ===== sv/jsu_out_buf.sv =====
// Result register holding the words of one input and handing them out one at a time.
module jsu_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  jsu_pkg::bundle_t bundle_i,
  output logic             free_o,
  jsu_out_if.source        out_o
);

  jsu_pkg::bundle_t bund_q;
  logic             valid_q;
  logic [1:0]       idx_q;
  jsu_pkg::result_t cur;
  logic             is_last;
  logic             fire;

  // Select the word at the current position.
  always_comb begin
    case (idx_q)
      2'd0:    cur = bund_q.res[0];
      2'd1:    cur = bund_q.res[1];
      2'd2:    cur = bund_q.res[2];
      default: cur = bund_q.res[0];
    endcase
  end

  assign is_last = (2'(idx_q + 2'd1) == bund_q.count);
  assign fire    = valid_q && out_o.ready;
  assign free_o  = !valid_q || (fire && is_last);

  assign out_o.valid    = valid_q;
  assign out_o.out_byte = cur.data;
  assign out_o.status   = cur.status;
  assign out_o.last     = is_last;

  // Payload loads with each new set of words.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bund_q <= bundle_i;
    end
  end

  // Occupancy and position within the current set.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= 2'd0;
    end else if (fire) begin
      if (is_last) begin
        valid_q <= 1'b0;
        idx_q   <= 2'd0;
      end else begin
        idx_q <= 2'(idx_q + 2'd1);
      end
    end
  end

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("result register overwritten while words remain");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (bund_q.count != 2'd0))
    else $error("result register holds an empty set");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (idx_q < bund_q.count))
    else $error("result position past the end of the set");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the JSON string unescaper unit.
module testbench;

  // Input word kinds.
  localparam bit KindData = 1'b0;
  localparam bit KindEnd  = 1'b1;

  // Decoder scan modes tracked by the predictor.
  typedef enum logic [1:0] {
    WaitQuote = 2'd0,
    InText    = 2'd1,
    AfterEsc  = 2'd2,
    InHex     = 2'd3
  } scan_mode_e;

  // One input word waiting to be sent; drain holds it until all output has come.
  typedef struct {
    bit         kind;
    logic [7:0] in_byte;
    bit         drain;
  } pending_t;

  // One expected output word.
  typedef struct {
    logic [7:0]       data;
    jsu_pkg::status_e status;
    logic             last;
  } text_word_t;

  logic clk;
  logic rst_n;

  jsu_in_if  in_ch ();
  jsu_out_if out_ch ();

  json_string_unescaper_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  pending_t   pending_words[$];
  text_word_t decoded_words[$];

  // Predictor state.
  scan_mode_e  scan_mode = WaitQuote;
  logic [1:0]  hex_cnt   = '0;
  logic [15:0] code_pt   = '0;
  bit          hex_bad   = 1'b0;

  int  fail_count  = 0;
  int  sent_cnt    = 0;
  int  total_items = 0;
  int  tx_idle_pct = 29;
  int  rx_idle_pct = 86;
  bit  launch;
  pending_t   next_word;
  text_word_t want;

  logic [7:0] short_escapes [8] = '{jsu_pkg::ChLowerB, jsu_pkg::ChLowerF,
                                    jsu_pkg::ChLowerN, jsu_pkg::ChLowerR,
                                    jsu_pkg::ChLowerT, jsu_pkg::ChQuote,
                                    jsu_pkg::ChSlash, jsu_pkg::ChBackslash};

  // Clock generator.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  // Value of one hex digit; ok is low for any other character.
  function automatic logic [3:0] hex_nibble(input logic [7:0] c, output bit ok);
    ok = 1'b1;
    if (c >= "0" && c <= "9") return c[3:0];
    if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) return {1'b0, c[2:0]} + 4'd9;
    ok = 1'b0;
    return 4'd0;
  endfunction

  function automatic text_word_t word_of(input logic [7:0] data,
                                         input jsu_pkg::status_e status);
    return '{data: data, status: status, last: 1'b0};
  endfunction

  // Predict the output words caused by one accepted input word.
  task automatic unescape_word(input bit at_end, input logic [7:0] c);
    text_word_t res [$];
    bit         ok;
    logic [3:0] v;
    if (at_end) begin
      res.push_back(word_of(8'h00, jsu_pkg::ST_ERROR));
      scan_mode = WaitQuote;
    end else begin
      case (scan_mode)
        WaitQuote: begin
          if (c == jsu_pkg::ChQuote) scan_mode = InText;
          else res.push_back(word_of(8'h00, jsu_pkg::ST_ERROR));
        end
        InText: begin
          if (c == jsu_pkg::ChQuote) begin
            res.push_back(word_of(8'h00, jsu_pkg::ST_CLOSED));
            scan_mode = WaitQuote;
          end else if (c == jsu_pkg::ChBackslash) begin
            scan_mode = AfterEsc;
          end else begin
            res.push_back(word_of(c, jsu_pkg::ST_BYTE));
          end
        end
        AfterEsc: begin
          scan_mode = InText;
          case (c)
            jsu_pkg::ChLowerB: res.push_back(word_of(jsu_pkg::CtlBackspace, jsu_pkg::ST_BYTE));
            jsu_pkg::ChLowerF: res.push_back(word_of(jsu_pkg::CtlFormFeed, jsu_pkg::ST_BYTE));
            jsu_pkg::ChLowerN: res.push_back(word_of(jsu_pkg::CtlNewLine, jsu_pkg::ST_BYTE));
            jsu_pkg::ChLowerR: res.push_back(word_of(jsu_pkg::CtlReturn, jsu_pkg::ST_BYTE));
            jsu_pkg::ChLowerT: res.push_back(word_of(jsu_pkg::CtlTab, jsu_pkg::ST_BYTE));
            jsu_pkg::ChQuote, jsu_pkg::ChSlash, jsu_pkg::ChBackslash:
              res.push_back(word_of(c, jsu_pkg::ST_BYTE));
            jsu_pkg::ChLowerU: begin
              scan_mode = InHex;
              hex_cnt   = '0;
              code_pt   = '0;
              hex_bad   = 1'b0;
            end
            default: begin
              res.push_back(word_of(8'h00, jsu_pkg::ST_ERROR));
              scan_mode = WaitQuote;
            end
          endcase
        end
        default: begin
          v = hex_nibble(c, ok);
          if (!ok) hex_bad = 1'b1;
          code_pt = {code_pt[11:0], v};
          if (hex_cnt < 2'd3) begin
            hex_cnt = hex_cnt + 2'd1;
          end else begin
            hex_cnt   = '0;
            scan_mode = InText;
            if (hex_bad) begin
              res.push_back(word_of(8'h00, jsu_pkg::ST_ERROR));
              scan_mode = WaitQuote;
            end else if (code_pt < jsu_pkg::Utf8Max1) begin
              res.push_back(word_of(code_pt[7:0], jsu_pkg::ST_BYTE));
            end else if (code_pt < jsu_pkg::Utf8Max2) begin
              res.push_back(word_of(jsu_pkg::Lead2 | {3'b000, code_pt[10:6]},
                                    jsu_pkg::ST_BYTE));
              res.push_back(word_of(jsu_pkg::ContByte |
                                    ({2'b00, code_pt[5:0]} & jsu_pkg::ContMask),
                                    jsu_pkg::ST_BYTE));
            end else begin
              res.push_back(word_of(jsu_pkg::Lead3 | {4'h0, code_pt[15:12]},
                                    jsu_pkg::ST_BYTE));
              res.push_back(word_of(jsu_pkg::ContByte | {2'b00, code_pt[11:6]},
                                    jsu_pkg::ST_BYTE));
              res.push_back(word_of(jsu_pkg::ContByte | {2'b00, code_pt[5:0]},
                                    jsu_pkg::ST_BYTE));
            end
            hex_bad = 1'b0;
          end
        end
      endcase
    end
    for (int i = 0; i < res.size(); i++) begin
      res[i].last = (i == res.size() - 1);
      decoded_words.push_back(res[i]);
    end
  endtask

  // Stimulus helpers.
  task automatic push_item(input bit kind, input logic [7:0] b, input bit drain = 1'b0);
    pending_words.push_back('{kind: kind, in_byte: b, drain: drain});
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + v;
    return ($urandom_range(1) ? 8'h61 : 8'h41) + (v - 4'd10);
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    bit         ok;
    do begin
      c = 8'($urandom_range(255));
      void'(hex_nibble(c, ok));
    end while (ok);
    return c;
  endfunction

  // A \u escape; a digit position in bad_pos is replaced by a non-hex byte.
  task automatic push_uescape(input logic [15:0] cp, input int bad_pos = -1);
    push_item(KindData, jsu_pkg::ChBackslash);
    push_item(KindData, jsu_pkg::ChLowerU);
    for (int i = 3; i >= 0; i--) begin
      if (3 - i == bad_pos) push_item(KindData, non_hex_char());
      else push_item(KindData, hex_char(cp[i*4 +: 4]));
    end
  endtask

  // A quoted string with random content, mostly well formed.
  task automatic add_random_string(input bit drain_first);
    int         pieces;
    int         sel;
    logic [7:0] c;
    logic [15:0] cp;
    push_item(KindData, jsu_pkg::ChQuote, drain_first);
    pieces = int'($urandom_range(6));
    for (int p = 0; p < pieces; p++) begin
      sel = int'($urandom_range(9));
      if (sel < 5) begin
        do c = 8'($urandom_range(255));
        while (c == jsu_pkg::ChQuote || c == jsu_pkg::ChBackslash);
        push_item(KindData, c);
      end else if (sel < 8) begin
        push_item(KindData, jsu_pkg::ChBackslash);
        push_item(KindData, short_escapes[$urandom_range(7)]);
      end else begin
        case ($urandom_range(2))
          0: cp = 16'($urandom_range(16'h007f));
          1: cp = 16'($urandom_range(16'h07ff, 16'h0080));
          default: cp = 16'($urandom_range(16'hffff));
        endcase
        push_uescape(cp);
      end
    end
    // Close the string, or break it in one of several ways.
    sel = int'($urandom_range(99));
    if (sel < 80) begin
      push_item(KindData, jsu_pkg::ChQuote);
    end else if (sel < 84) begin
      push_item(KindEnd, 8'($urandom_range(255)));
    end else if (sel < 88) begin
      push_item(KindData, jsu_pkg::ChBackslash);
      push_item(KindEnd, 8'($urandom_range(255)));
    end else if (sel < 92) begin
      push_item(KindData, jsu_pkg::ChBackslash);
      push_item(KindData, jsu_pkg::ChLowerU);
      repeat ($urandom_range(3)) push_item(KindData, hex_char(4'($urandom_range(15))));
      push_item(KindEnd, 8'($urandom_range(255)));
    end else if (sel < 96) begin
      push_item(KindData, jsu_pkg::ChBackslash);
      do c = 8'($urandom_range(255));
      while (c inside {jsu_pkg::ChLowerB, jsu_pkg::ChLowerF, jsu_pkg::ChLowerN,
                       jsu_pkg::ChLowerR, jsu_pkg::ChLowerT, jsu_pkg::ChQuote,
                       jsu_pkg::ChSlash, jsu_pkg::ChBackslash, jsu_pkg::ChLowerU});
      push_item(KindData, c);
    end else begin
      push_uescape(16'($urandom_range(16'hffff)), int'($urandom_range(3)));
    end
  endtask

  task automatic flag_failure(input string msg);
    if (fail_count < 10) $display("mismatch: %s", msg);
    fail_count++;
  endtask

  // Driver: presents pending words and predicts on each accepted word.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.kind    <= KindData;
      in_ch.in_byte <= 8'h00;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        unescape_word(in_ch.kind, in_ch.in_byte);
        sent_cnt = sent_cnt + 1;
        if (sent_cnt * 3 < total_items) begin
          tx_idle_pct <= 29;
          rx_idle_pct <= 86;
        end else if (sent_cnt * 3 < total_items * 2) begin
          tx_idle_pct <= 86;
          rx_idle_pct <= 29;
        end else begin
          tx_idle_pct <= 0;
          rx_idle_pct <= 0;
        end
      end
      if (!in_ch.valid || in_ch.ready) begin
        launch = pending_words.size() != 0 && $urandom_range(99) >= tx_idle_pct;
        if (launch && pending_words[0].drain && decoded_words.size() != 0) launch = 1'b0;
        if (launch) begin
          next_word      = pending_words.pop_front();
          in_ch.valid   <= 1'b1;
          in_ch.kind    <= next_word.kind;
          in_ch.in_byte <= next_word.in_byte;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted output word against the oldest prediction.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (decoded_words.size() == 0) begin
          flag_failure($sformatf("unexpected word data=%h status=%0d last=%b",
                                 out_ch.out_byte, out_ch.status, out_ch.last));
        end else begin
          want = decoded_words.pop_front();
          if (out_ch.out_byte !== want.data || out_ch.status !== want.status ||
              out_ch.last !== want.last)
            flag_failure($sformatf("expected data=%h status=%0d last=%b, got %h %0d %b",
                                   want.data, want.status, want.last,
                                   out_ch.out_byte, out_ch.status, out_ch.last));
        end
      end
      out_ch.ready <= $urandom_range(99) >= rx_idle_pct;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    rst_n = 1'b0;

    // Directed part: errors while waiting, byte extremes, escapes and breaks.
    push_item(KindEnd, 8'hff);
    push_item(KindData, 8'hff);
    push_item(KindData, jsu_pkg::ChQuote);
    push_item(KindData, 8'h00);
    push_item(KindData, 8'hff);
    push_item(KindData, jsu_pkg::ChBackslash);
    push_item(KindData, jsu_pkg::ChLowerT);
    push_uescape(16'h0000);
    push_uescape(16'h07ff);
    push_uescape(16'hffff);
    push_item(KindData, jsu_pkg::ChQuote);
    push_item(KindData, jsu_pkg::ChQuote);
    push_item(KindData, jsu_pkg::ChBackslash);
    push_item(KindData, "q");
    push_item(KindData, jsu_pkg::ChQuote);
    push_uescape(16'h0041, 0);
    push_item(KindEnd, 8'h00);

    // Random part: mostly strings, with bursts of noise between them.
    add_random_string(1'b1);
    while (pending_words.size() < 210) begin
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(3, 1))
          push_item($urandom_range(3) == 0, 8'($urandom_range(255)));
      end else begin
        add_random_string($urandom_range(7) == 0);
      end
    end
    total_items = pending_words.size();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    do @(negedge clk);
    while (pending_words.size() != 0 || in_ch.valid || decoded_words.size() != 0);
    repeat (10) @(negedge clk);

    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
